[rtl/arc4_pkg.sv]
// ----------------------------------------------------------------------------
// arc4_pkg
// Shared types and constants of the ARC4 stream cipher block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arc4_pkg;

  localparam int unsigned PermDepth = 256;
  localparam int unsigned ByteW     = 8;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [3:0]       state_t;

  localparam state_t StIdle  = 4'd0;
  localparam state_t StInit  = 4'd1;
  localparam state_t StKsRd  = 4'd2;
  localparam state_t StKsJ   = 4'd3;
  localparam state_t StKsWk  = 4'd4;
  localparam state_t StKsWj  = 4'd5;
  localparam state_t StPgRj  = 4'd6;
  localparam state_t StPgWi  = 4'd7;
  localparam state_t StPgWj  = 4'd8;

  localparam logic ReqKey  = 1'b0;
  localparam logic ReqData = 1'b1;

endpackage

[rtl/arc4_stream_cipher_top.sv]
// ----------------------------------------------------------------------------
// arc4_stream_cipher_top
// ARC4 byte stream cipher: key store, key schedule and keystream generation
// around one 256-entry permutation memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o | req_type_i, byte_in_i, last_i
//  out     | output    | out_valid_o/out_ready_i | byte_out_o, last_out_o, keyed_o
//
//  Key bytes, and data bytes before a key, are taken in StIdle. A keyed data byte
//  runs a read, read, swap-write, swap-write sequence on the permutation memory's
//  read port and write port. A last key byte or last keyed data byte then runs the
//  schedule: a fill of all 256 entries, then 256 key mixing steps.
//  After reset no clearing pass runs; the block is ready at once.
//  in_ready_o is low while a byte or the schedule is in flight and while the
//  output register holds a beat that is not taken in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arc4_stream_cipher_top #(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  arc4_pkg::byte_t      byte_in_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output arc4_pkg::byte_t      byte_out_o,
  output logic                 last_out_o,
  output logic                 keyed_o
);
  import arc4_pkg::*;

  localparam int unsigned KeyAw = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned KeyCw = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [KeyCw-1:0] KeyMax = KeyCw'(MAX_KEY_BYTES);

  byte_t perm_mem [PermDepth];
  byte_t key_mem  [MAX_KEY_BYTES];

  state_t            state_q, state_d;
  byte_t             cnt_q, cnt_d;
  byte_t             i_q, i_d;
  byte_t             j_q, j_d;
  logic [KeyAw-1:0]  kidx_q, kidx_d;
  logic [KeyCw-1:0]  key_count_q, key_count_d;
  logic              key_ready_q, key_ready_d;
  logic              key_restart_q, key_restart_d;
  logic              out_valid_q, out_valid_d;

  byte_t             si_q, si_d;
  byte_t             sj_q, sj_d;
  byte_t             data_q, data_d;
  logic              last_q, last_d;
  logic              fwd_q, fwd_d;
  byte_t             fwd_val_q, fwd_val_d;
  byte_t             out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic              out_keyed_q, out_keyed_d;

  logic              perm_we;
  byte_t             perm_waddr, perm_wdata, perm_raddr, perm_rdata_q;
  logic              key_we;
  logic [KeyAw-1:0]  key_waddr, key_raddr;
  byte_t             key_wdata, key_rdata_q;

  logic              in_fire;
  logic [KeyCw-1:0]  count_eff;
  byte_t             j_new, t_addr;

  // Memories
  always_ff @(posedge clk_i) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    perm_rdata_q <= perm_mem[perm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rdata_q <= key_mem[key_raddr];
  end

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign count_eff  = key_restart_q ? '0 : key_count_q;
  assign j_new      = j_q + perm_rdata_q + key_rdata_q;
  assign t_addr     = si_q + perm_rdata_q;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    i_d           = i_q;
    j_d           = j_q;
    kidx_d        = kidx_q;
    key_count_d   = key_count_q;
    key_ready_d   = key_ready_q;
    key_restart_d = key_restart_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    si_d          = si_q;
    sj_d          = sj_q;
    data_d        = data_q;
    last_d        = last_q;
    fwd_d         = fwd_q;
    fwd_val_d     = fwd_val_q;
    out_byte_d    = out_byte_q;
    out_last_d    = out_last_q;
    out_keyed_d   = out_keyed_q;
    perm_we       = 1'b0;
    perm_waddr    = cnt_q;
    perm_wdata    = cnt_q;
    perm_raddr    = cnt_q;
    key_we        = 1'b0;
    key_waddr     = count_eff[KeyAw-1:0];
    key_wdata     = byte_in_i;
    key_raddr     = kidx_q;

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (req_type_i == ReqKey) begin
            key_restart_d = 1'b0;
            key_count_d   = count_eff;
            if (key_restart_q) begin
              key_ready_d = 1'b0;
            end
            if (count_eff < KeyMax) begin
              key_we      = 1'b1;
              key_count_d = count_eff + KeyCw'(1);
            end
            if (last_i) begin
              key_restart_d = 1'b1;
              key_ready_d   = 1'b1;
              cnt_d         = '0;
              state_d       = StInit;
            end
          end else if (!key_ready_q) begin
            out_valid_d = 1'b1;
            out_byte_d  = '0;
            out_last_d  = last_i;
            out_keyed_d = 1'b0;
          end else begin
            i_d        = i_q + 8'd1;
            perm_raddr = i_q + 8'd1;
            data_d     = byte_in_i;
            last_d     = last_i;
            state_d    = StPgRj;
          end
        end
      end
      StInit: begin
        perm_we = 1'b1;
        cnt_d   = cnt_q + 8'd1;
        if (cnt_q == 8'hFF) begin
          j_d     = '0;
          kidx_d  = '0;
          state_d = StKsRd;
        end
      end
      StKsRd: begin
        state_d = StKsJ;
      end
      StKsJ: begin
        si_d       = perm_rdata_q;
        j_d        = j_new;
        perm_raddr = j_new;
        state_d    = StKsWk;
      end
      StKsWk: begin
        perm_we    = 1'b1;
        perm_wdata = perm_rdata_q;
        state_d    = StKsWj;
      end
      StKsWj: begin
        perm_we    = 1'b1;
        perm_waddr = j_q;
        perm_wdata = si_q;
        cnt_d      = cnt_q + 8'd1;
        if ((KeyCw'(kidx_q) + KeyCw'(1)) == key_count_q) begin
          kidx_d = '0;
        end else begin
          kidx_d = kidx_q + KeyAw'(1);
        end
        if (cnt_q == 8'hFF) begin
          i_d     = '0;
          j_d     = '0;
          state_d = StIdle;
        end else begin
          state_d = StKsRd;
        end
      end
      StPgRj: begin
        si_d       = perm_rdata_q;
        j_d        = j_q + perm_rdata_q;
        perm_raddr = j_q + perm_rdata_q;
        state_d    = StPgWi;
      end
      StPgWi: begin
        sj_d       = perm_rdata_q;
        perm_we    = 1'b1;
        perm_waddr = i_q;
        perm_wdata = perm_rdata_q;
        perm_raddr = t_addr;
        // forward the pending swap to the keystream read
        if (t_addr == i_q) begin
          fwd_d     = 1'b1;
          fwd_val_d = perm_rdata_q;
        end else if (t_addr == j_q) begin
          fwd_d     = 1'b1;
          fwd_val_d = si_q;
        end else begin
          fwd_d     = 1'b0;
          fwd_val_d = si_q;
        end
        state_d = StPgWj;
      end
      StPgWj: begin
        perm_we     = 1'b1;
        perm_waddr  = j_q;
        perm_wdata  = si_q;
        out_valid_d = 1'b1;
        out_byte_d  = data_q ^ (fwd_q ? fwd_val_q : perm_rdata_q);
        out_last_d  = last_q;
        out_keyed_d = 1'b1;
        if (last_q) begin
          cnt_d   = '0;
          state_d = StInit;
        end else begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      cnt_q         <= '0;
      i_q           <= '0;
      j_q           <= '0;
      kidx_q        <= '0;
      key_count_q   <= '0;
      key_ready_q   <= 1'b0;
      key_restart_q <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      i_q           <= i_d;
      j_q           <= j_d;
      kidx_q        <= kidx_d;
      key_count_q   <= key_count_d;
      key_ready_q   <= key_ready_d;
      key_restart_q <= key_restart_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q        <= si_d;
    sj_q        <= sj_d;
    data_q      <= data_d;
    last_q      <= last_d;
    fwd_q       <= fwd_d;
    fwd_val_q   <= fwd_val_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_keyed_q <= out_keyed_d;
  end

  assign out_valid_o = out_valid_q;
  assign byte_out_o  = out_byte_q;
  assign last_out_o  = out_last_q;
  assign keyed_o     = out_keyed_q;

  // sj_q holds the fetched entry for debug visibility of the swap
  a_swap_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPgWj) |-> (sj_q == $past(perm_rdata_q)))
    else $error("swap pair lost");

  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPgWj) |-> !out_valid_q)
    else $error("output register busy at keystream result");

  a_keyed_for_prga: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPgRj) |-> key_ready_q)
    else $error("keystream step without a key");

  a_kidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StKsRd) |-> ((KeyCw'(kidx_q) < key_count_q) && (key_count_q != '0)))
    else $error("key index beyond key length");

  a_unkeyed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_keyed_q) |-> (out_byte_q == '0))
    else $error("unkeyed result not zero");

endmodule

[bench/tb_arc4_stream_cipher_top.sv]
// ----------------------------------------------------------------------------
// tb_arc4_stream_cipher_top
// Self-checking bench for the ARC4 stream cipher block. A short table of
// directed beats covers unkeyed data, key loads, message ends and keys cut
// into by data. Random messages under random keys follow, with broken
// sequences and noise mixed in. Both channels idle and stall at random in
// rotating pacing phases. A bench-side cipher model predicts every output
// beat, and each beat taken is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_arc4_stream_cipher_top;

  import arc4_pkg::*;

  localparam int unsigned KeyMax       = 256;
  localparam int          ItemTarget   = 800;
  localparam int          SettleCycles = 1600;
  localparam int          HoldCycles   = 600;
  localparam longint      CycleLimit   = 64'd8_000_000;
  localparam int          NumDirRows   = 18;

  typedef struct packed {
    byte_t data;
    logic  last;
    logic  keyed;
  } cipher_beat_t;

  typedef struct packed {
    logic         req;
    byte_t        b;
    logic         lst;
    logic         typed;
    cipher_beat_t beat;
  } stim_row_t;

  localparam stim_row_t DirRows [NumDirRows] = '{
    '{ReqData, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{ReqData, 8'hFF, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{ReqKey,  8'h01, 1'b0, 1'b0, '0},
    '{ReqKey,  8'h23, 1'b0, 1'b0, '0},
    '{ReqKey,  8'h45, 1'b0, 1'b0, '0},
    '{ReqKey,  8'hFF, 1'b1, 1'b0, '0},
    '{ReqData, 8'h00, 1'b0, 1'b0, '0},
    '{ReqData, 8'hFF, 1'b0, 1'b0, '0},
    '{ReqData, 8'hA5, 1'b1, 1'b0, '0},
    '{ReqData, 8'h5A, 1'b0, 1'b0, '0},
    '{ReqKey,  8'h80, 1'b0, 1'b0, '0},
    '{ReqData, 8'h11, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{ReqData, 8'hEE, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{ReqKey,  8'h7F, 1'b1, 1'b0, '0},
    '{ReqData, 8'h00, 1'b0, 1'b0, '0},
    '{ReqData, 8'hFF, 1'b1, 1'b0, '0},
    '{ReqKey,  8'h00, 1'b1, 1'b0, '0},
    '{ReqData, 8'h3C, 1'b1, 1'b0, '0}
  };

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  logic  req_type_i;
  byte_t byte_in_i;
  logic  last_i;
  logic  out_valid_o;
  logic  out_ready_i;
  byte_t byte_out_o;
  logic  last_out_o;
  logic  keyed_o;

  byte_t perm_state [PermDepth];
  byte_t key_mem [KeyMax];
  int    key_len;
  byte_t idx_i;
  byte_t idx_j;
  logic  key_valid;
  logic  key_fresh;

  cipher_beat_t beats_due [$];
  int           mismatch_cnt;
  int           items_sent;
  int           send_idle_pct;
  int           recv_stall_pct;
  bit           hold_req;
  int           hold_left;
  longint       cycle_cnt;

  arc4_stream_cipher_top #(
    .MAX_KEY_BYTES(KeyMax)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .byte_in_i  (byte_in_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .byte_out_o (byte_out_o),
    .last_out_o (last_out_o),
    .keyed_o    (keyed_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void schedule_key();
    byte_t jx;
    byte_t t;
    int    len;
    len = (key_len == 0) ? 1 : key_len;
    for (int k = 0; k < PermDepth; k++) perm_state[k] = byte_t'(k);
    jx = '0;
    for (int k = 0; k < PermDepth; k++) begin
      jx = jx + perm_state[k] + key_mem[k % len];
      t = perm_state[k];
      perm_state[k] = perm_state[jx];
      perm_state[jx] = t;
    end
    idx_i = '0;
    idx_j = '0;
  endfunction

  function automatic logic advance_cipher(input logic req, input byte_t b, input logic lst,
                                          output cipher_beat_t beat, output logic dropped);
    byte_t t;
    byte_t ks;
    beat = '0;
    dropped = 1'b0;
    if (req == ReqKey) begin
      if (key_fresh) begin
        key_len = 0;
        key_valid = 1'b0;
        key_fresh = 1'b0;
      end
      if (key_len < KeyMax) begin
        key_mem[key_len % 256] = b;
        key_len++;
      end else begin
        dropped = 1'b1;
      end
      if (lst) begin
        key_fresh = 1'b1;
        if (key_len > 0) begin
          schedule_key();
          key_valid = 1'b1;
        end
      end
      return 1'b0;
    end
    beat.last = lst;
    if (!key_valid) return 1'b1;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm_state[idx_i];
    t = perm_state[idx_i];
    perm_state[idx_i] = perm_state[idx_j];
    perm_state[idx_j] = t;
    ks = perm_state[byte_t'(perm_state[idx_i] + perm_state[idx_j])];
    beat.data = b ^ ks;
    beat.keyed = 1'b1;
    if (lst) schedule_key();
    return 1'b1;
  endfunction

  function automatic int pick_key_len();
    if ($urandom_range(24) == 0) return $urandom_range(250, 300);
    return $urandom_range(1, 16);
  endfunction

  function automatic void set_pacing(input int slot);
    case (slot % 4)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 47;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 47;
      end
      default: begin
        send_idle_pct = 17;
        recv_stall_pct = 17;
      end
    endcase
  endfunction

  task automatic send_item(input logic req, input byte_t b, input logic lst,
                           input logic typed, input cipher_beat_t typed_beat);
    cipher_beat_t beat;
    logic         dropped;
    logic         has_beat;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    byte_in_i  <= b;
    last_i     <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    has_beat = advance_cipher(req, b, lst, beat, dropped);
    if (typed) beat = typed_beat;
    if (has_beat) beats_due.push_back(beat);
    if (!dropped) items_sent++;
  endtask

  task automatic load_key(input int n);
    for (int k = 0; k < n; k++) begin
      send_item(ReqKey, byte_t'($urandom_range(255)), k == n - 1, 1'b0, '0);
    end
  endtask

  task automatic send_message(input int n, input logic close);
    for (int k = 0; k < n; k++) begin
      send_item(ReqData, byte_t'($urandom_range(255)), close && (k == n - 1), 1'b0, '0);
    end
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_beat();
    cipher_beat_t want;
    if (beats_due.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("unexpected beat: byte_out=%h last_out=%b keyed=%b",
                 byte_out_o, last_out_o, keyed_o);
      end
      return;
    end
    want = beats_due.pop_front();
    if (byte_out_o !== want.data || last_out_o !== want.last || keyed_o !== want.keyed) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("beat mismatch: exp byte_out=%h last_out=%b keyed=%b, got %h %b %b",
                 want.data, want.last, want.keyed, byte_out_o, last_out_o, keyed_o);
      end
    end
  endtask

  initial begin
    out_ready_i <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) check_beat();
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("arc4_stream_cipher_top verification failed");
    $finish;
  end

  initial begin
    int pace_slot;
    int pick;
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    req_type_i <= ReqKey;
    byte_in_i  <= '0;
    last_i     <= 1'b0;
    mismatch_cnt = 0;
    items_sent = 0;
    hold_req = 1'b0;
    key_len = 0;
    idx_i = '0;
    idx_j = '0;
    key_valid = 1'b0;
    key_fresh = 1'b1;
    set_pacing(0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumDirRows; r++) begin
      send_item(DirRows[r].req, DirRows[r].b, DirRows[r].lst, DirRows[r].typed,
                DirRows[r].beat);
    end

    load_key(300);
    send_message($urandom_range(1, 24), 1'b1);
    pace_slot = 0;
    while (items_sent < ItemTarget) begin
      if (items_sent / 100 != pace_slot) begin
        pace_slot = items_sent / 100;
        wait_results_done();
        set_pacing(pace_slot);
        if (pace_slot % 4 == 2) hold_req = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        if (!key_valid || $urandom_range(3) == 0) load_key(pick_key_len());
        send_message($urandom_range(1, 24), 1'b1);
      end else if (pick < 82) begin
        if (!key_valid) load_key(pick_key_len());
        send_message($urandom_range(1, 8), 1'b0);
        load_key(pick_key_len());
      end else if (pick < 94) begin
        for (int k = $urandom_range(1, 3); k > 0; k--) begin
          send_item(ReqKey, byte_t'($urandom_range(255)), 1'b0, 1'b0, '0);
        end
        for (int k = $urandom_range(1, 4); k > 0; k--) begin
          send_item(ReqData, byte_t'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
        end
        load_key($urandom_range(1, 8));
      end else begin
        send_item(1'($urandom_range(1)), byte_t'($urandom_range(255)),
                  1'($urandom_range(1)), 1'b0, '0);
      end
    end

    wait_results_done();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && beats_due.size() == 0) begin
      $display("arc4_stream_cipher_top verification clean");
    end else begin
      $display("arc4_stream_cipher_top verification failed");
    end
    $finish;
  end

endmodule
